FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the maze walker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/mdw_pkg.sv
// Shared types, codes and constants of the maze walker.
package mdw_pkg;

	localparam int MAX_ROWS    = 16;
	localparam int MAX_COLS    = 16;
	localparam int COORD_W     = 4;
	localparam int USED_W      = 5;
	localparam int MAP_DEPTH   = MAX_ROWS * MAX_COLS;
	localparam int MAP_AW      = $clog2(MAP_DEPTH);
	localparam int CELL_W      = 2;
	localparam int STACK_DEPTH = 256;
	localparam int STACK_AW    = $clog2(STACK_DEPTH);
	localparam int DEPTH_W     = STACK_AW + 1;
	localparam int POS_W       = 2 * COORD_W;

	// Coordinates are 4 bits wide, so the grid never exceeds 16 on either axis.
	localparam int ROW_LIM = (MAX_ROWS < 16) ? MAX_ROWS : 16;
	localparam int COL_LIM = (MAX_COLS < 16) ? MAX_COLS : 16;

	// Cell encoding: bit 0 wall, bit 1 visited.
	localparam logic [CELL_W-1:0] CELL_OPEN    = 2'b00;
	localparam logic [CELL_W-1:0] CELL_VISITED = 2'b10;
	localparam int                CELL_WALL_B  = 0;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STEP  = 2'd2;

	typedef enum logic [2:0] {
		EV_WRITTEN   = 3'd0,
		EV_STARTED   = 3'd1,
		EV_REJECTED  = 3'd2,
		EV_MOVED     = 3'd3,
		EV_BACKTRACK = 3'd4,
		EV_GOAL      = 3'd5,
		EV_UNREACH   = 3'd6,
		EV_IGNORED   = 3'd7
	} ev_t;

	typedef enum logic [1:0] {
		CFG_ROWS_USED = 2'd0,
		CFG_COLS_USED = 2'd1,
		CFG_GOAL_ROW  = 2'd2,
		CFG_GOAL_COL  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [MAP_AW-1:0] addr;
		logic [CELL_W-1:0] wr_data;
	} map_req_t;

	// Saturate a size register at the axis limit.
	function automatic logic [USED_W-1:0] grid_lim(input logic [USED_W-1:0] used,
			input logic [USED_W-1:0] lim);
		return (used > lim) ? lim : used;
	endfunction

endpackage

FILE: hw/rtl/mdw_cmd_if.sv
// Command channel of the maze walker: one word per operation.
interface mdw_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [3:0] row;
	logic [3:0] col;
	logic       wall;

	modport source(output valid, output operation, output row, output col, output wall,
		input ready);
	modport sink(input valid, input operation, input row, input col, input wall,
		output ready);
endinterface

FILE: hw/rtl/mdw_rsp_if.sv
// Result channel of the maze walker: one word per operation.
interface mdw_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] pos_row;
	logic [3:0] pos_col;
	logic [2:0] event_res;

	modport source(output valid, output pos_row, output pos_col, output event_res,
		input ready);
	modport sink(input valid, input pos_row, input pos_col, input event_res,
		output ready);
endinterface

FILE: hw/rtl/mdw_cell_store.sv
// Cell map memory with per-entry valid bits; unwritten cells read as open.
module mdw_cell_store (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mdw_pkg::map_req_t                   req,
	output logic [mdw_pkg::CELL_W-1:0]          rd_data
);
	import mdw_pkg::*;

	logic [CELL_W-1:0]    cell_mem [MAP_DEPTH];
	logic [MAP_DEPTH-1:0] vld_q;
	logic [CELL_W-1:0]    rd_mem_s1;
	logic                 rd_vld_s1;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			cell_mem[req.addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_mem_s1 <= cell_mem[req.addr];
			rd_vld_s1 <= vld_q[req.addr];
		end
	end

	// Mark written entries; reset drops the whole map back to open.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.wr_en) begin
			vld_q[req.addr] <= 1'b1;
		end
	end

	assign rd_data = rd_vld_s1 ? rd_mem_s1 : CELL_OPEN;

endmodule

FILE: hw/rtl/maze_dfs_walker.sv
// Top level of the depth-first maze walker: sequencer, path stack and config.
//
// Usage:
//   cmd carries one word per operation: write a map cell (wall or open,
//   visited mark cleared), start at an entrance, or take one walk step.
//   rsp returns exactly one word per command: the current position after
//   the operation and an event code.
//   cfg_we/cfg_index/cfg_wdata set grid rows, grid columns and the goal
//   cell; write them only while no command is in flight.
// Sequencing:
//   One command at a time. The single-port cell map has a registered
//   read, so each neighbor is probed in a read-issue state and a check
//   state; neighbors off the grid are skipped. A write stores its cell,
//   a start reads and checks its entrance, and a step probes neighbors
//   until one is free; a dead end backtracks through the path stack.
// Reset:
//   arst_n clears the map to open and unvisited (valid bits), the walk to
//   idle at row 0 column 0, and the config to 10 rows, 12 columns, goal
//   at row 4 column 11. The path stack holds no reset value.
// Stall:
//   The result register holds its word while rsp.ready is low; the next
//   command is still taken and waits for the register to free up before
//   its own result is loaded.
`include "assert_macros.svh"

module maze_dfs_walker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_index,
	input  logic [mdw_pkg::USED_W-1:0] cfg_wdata,
	mdw_cmd_if.sink                cmd,
	mdw_rsp_if.source              rsp
);
	import mdw_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISP,
		S_SCHK,
		S_NISS,
		S_NCHK,
		S_DEAD,
		S_POP,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		WS_IDLE,
		WS_WALK,
		WS_GOAL,
		WS_UNREACH
	} walk_t;

	typedef enum logic [1:0] {
		DIR_LEFT,
		DIR_RIGHT,
		DIR_DOWN,
		DIR_UP
	} dir_t;

	state_t               state_q;
	walk_t                status_q;
	dir_t                 dir_q;
	ev_t                  ev_q;
	logic [1:0]           op_q;
	logic [COORD_W-1:0]   row_q, col_q;
	logic                 wall_q;
	logic [COORD_W-1:0]   cur_row_q, cur_col_q, entry_row_q, entry_col_q;
	logic [DEPTH_W-1:0]   depth_q;
	logic                 rsp_valid_q;
	logic [COORD_W-1:0]   rsp_row_q, rsp_col_q;
	ev_t                  rsp_ev_q;

	logic [USED_W-1:0]    rows_used_q, cols_used_q;
	logic [COORD_W-1:0]   goal_row_q, goal_col_q;

	map_req_t             map_req;
	logic [CELL_W-1:0]    map_rd;

	logic [POS_W-1:0]     stack_mem [STACK_DEPTH];
	logic                 stk_we, stk_re;
	logic [STACK_AW-1:0]  stk_waddr, stk_raddr;
	logic [POS_W-1:0]     stk_wdata, stk_rd_s1;

	logic [USED_W-1:0]    lim_rows, lim_cols;
	logic [USED_W-1:0]    cand_r5, cand_c5;
	logic                 cand_ok;
	logic [COORD_W-1:0]   cand_row, cand_col;
	logic                 start_ok, cell_free, at_goal, dead_stop, last_dir, out_free;
	logic [DEPTH_W-1:0]   depth_dec, depth_dec2;

	// ------------------------------------------------------------------
	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_used_q <= USED_W'(10);
			cols_used_q <= USED_W'(12);
			goal_row_q  <= COORD_W'(4);
			goal_col_q  <= COORD_W'(11);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ROWS_USED: rows_used_q <= cfg_wdata;
				CFG_COLS_USED: cols_used_q <= cfg_wdata;
				CFG_GOAL_ROW:  goal_row_q  <= cfg_wdata[COORD_W-1:0];
				CFG_GOAL_COL:  goal_col_q  <= cfg_wdata[COORD_W-1:0];
				default:       ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Grid limits and the neighbor under test. dir_q and the current
	// position hold between issuing the read and checking its data.
	assign lim_rows = grid_lim(rows_used_q, USED_W'(ROW_LIM));
	assign lim_cols = grid_lim(cols_used_q, USED_W'(COL_LIM));

	always_comb begin
		cand_r5 = {1'b0, cur_row_q};
		cand_c5 = {1'b0, cur_col_q};
		cand_ok = 1'b1;
		unique case (dir_q)
			DIR_LEFT: begin
				cand_ok = (cur_col_q != '0);
				cand_c5 = {1'b0, cur_col_q} - USED_W'(1);
			end
			DIR_RIGHT: begin
				cand_c5 = {1'b0, cur_col_q} + USED_W'(1);
			end
			DIR_DOWN: begin
				cand_r5 = {1'b0, cur_row_q} + USED_W'(1);
			end
			DIR_UP: begin
				cand_ok = (cur_row_q != '0);
				cand_r5 = {1'b0, cur_row_q} - USED_W'(1);
			end
			default: ;
		endcase
		// Cells outside the grid in use count as walls.
		cand_ok = cand_ok && (cand_r5 < lim_rows) && (cand_c5 < lim_cols);
	end

	assign cand_row   = cand_r5[COORD_W-1:0];
	assign cand_col   = cand_c5[COORD_W-1:0];
	assign start_ok   = ({1'b0, row_q} < lim_rows) && ({1'b0, col_q} < lim_cols);
	assign cell_free  = (map_rd == CELL_OPEN);
	assign at_goal    = (cur_row_q == goal_row_q) && (cur_col_q == goal_col_q);
	assign last_dir   = (dir_q == DIR_UP);
	assign dead_stop  = ((cur_row_q == entry_row_q) && (cur_col_q == entry_col_q))
			|| (depth_q <= DEPTH_W'(1));
	assign depth_dec  = depth_q - DEPTH_W'(1);
	assign depth_dec2 = depth_q - DEPTH_W'(2);
	assign out_free   = !rsp_valid_q || rsp.ready;

	// ------------------------------------------------------------------
	// Memory requests. Reads and writes of one command fall in different
	// states, and a command starts only after the previous one wrote back,
	// so no access overlaps another on the same entry.
	always_comb begin
		map_req   = '0;
		stk_we    = 1'b0;
		stk_re    = 1'b0;
		stk_waddr = '0;
		stk_raddr = depth_dec2[STACK_AW-1:0];
		stk_wdata = {cand_row, cand_col};
		unique case (state_q)
			S_DISP: begin
				if (op_q == OP_WRITE) begin
					map_req.wr_en   = 1'b1;
					map_req.addr    = {row_q, col_q};
					map_req.wr_data = {1'b0, wall_q};
				end else if (op_q == OP_START && start_ok) begin
					map_req.rd_en = 1'b1;
					map_req.addr  = {row_q, col_q};
				end
			end
			S_NISS: begin
				if (cand_ok) begin
					map_req.rd_en = 1'b1;
					map_req.addr  = {cand_row, cand_col};
				end
			end
			S_SCHK: begin
				if (!map_rd[CELL_WALL_B]) begin
					map_req.wr_en   = 1'b1;
					map_req.addr    = {row_q, col_q};
					map_req.wr_data = CELL_VISITED;
					stk_we          = 1'b1;
					stk_waddr       = '0;
					stk_wdata       = {row_q, col_q};
				end
			end
			S_NCHK: begin
				if (cell_free) begin
					map_req.wr_en   = 1'b1;
					map_req.addr    = {cand_row, cand_col};
					map_req.wr_data = CELL_VISITED;
					stk_we          = 1'b1;
					// A full stack overwrites its top entry.
					stk_waddr       = depth_q[STACK_AW] ? STACK_AW'(STACK_DEPTH - 1)
							: depth_q[STACK_AW-1:0];
				end
			end
			S_DEAD: begin
				stk_re = !dead_stop;
			end
			default: ;
		endcase
	end

	mdw_cell_store u_cell_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (map_req),
		.rd_data (map_rd)
	);

	// Path stack: one write and one registered read port.
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stack_mem[stk_waddr] <= stk_wdata;
		end
		if (stk_re) begin
			stk_rd_s1 <= stack_mem[stk_raddr];
		end
	end

	// ------------------------------------------------------------------
	// Sequencer, walk state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			status_q    <= WS_IDLE;
			dir_q       <= DIR_LEFT;
			ev_q        <= EV_IGNORED;
			op_q        <= OP_WRITE;
			row_q       <= '0;
			col_q       <= '0;
			wall_q      <= 1'b0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			entry_row_q <= '0;
			entry_col_q <= '0;
			depth_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_row_q   <= '0;
			rsp_col_q   <= '0;
			rsp_ev_q    <= EV_IGNORED;
		end else begin
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						op_q    <= cmd.operation;
						row_q   <= cmd.row;
						col_q   <= cmd.col;
						wall_q  <= cmd.wall;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					state_q <= S_FIN;
					dir_q   <= DIR_LEFT;
					case (op_q)
						OP_WRITE: ev_q <= EV_WRITTEN;
						OP_START: begin
							ev_q <= EV_REJECTED;
							if (start_ok) begin
								state_q <= S_SCHK;
							end
						end
						OP_STEP: begin
							if (status_q != WS_WALK) begin
								ev_q <= EV_IGNORED;
							end else if (at_goal) begin
								status_q <= WS_GOAL;
								ev_q     <= EV_GOAL;
							end else begin
								state_q <= S_NISS;
							end
						end
						default: ev_q <= EV_IGNORED;
					endcase
				end
				S_SCHK: begin
					// A wall at the entrance rejects the start (event set above).
					if (!map_rd[CELL_WALL_B]) begin
						entry_row_q <= row_q;
						entry_col_q <= col_q;
						cur_row_q   <= row_q;
						cur_col_q   <= col_q;
						depth_q     <= DEPTH_W'(1);
						status_q    <= WS_WALK;
						ev_q        <= EV_STARTED;
					end
					state_q <= S_FIN;
				end
				S_NISS: begin
					// Skip neighbors off the grid without a read.
					if (cand_ok) begin
						state_q <= S_NCHK;
					end else if (last_dir) begin
						state_q <= S_DEAD;
					end else begin
						dir_q <= dir_t'(dir_q + 2'd1);
					end
				end
				S_NCHK: begin
					if (cell_free) begin
						cur_row_q <= cand_row;
						cur_col_q <= cand_col;
						if (!depth_q[STACK_AW]) begin
							depth_q <= depth_q + DEPTH_W'(1);
						end
						ev_q    <= EV_MOVED;
						state_q <= S_FIN;
					end else if (last_dir) begin
						state_q <= S_DEAD;
					end else begin
						dir_q   <= dir_t'(dir_q + 2'd1);
						state_q <= S_NISS;
					end
				end
				S_DEAD: begin
					if (dead_stop) begin
						status_q <= WS_UNREACH;
						ev_q     <= EV_UNREACH;
						state_q  <= S_FIN;
					end else begin
						depth_q <= depth_dec;
						state_q <= S_POP;
					end
				end
				S_POP: begin
					// Return to the new stack top.
					cur_row_q <= stk_rd_s1[POS_W-1:COORD_W];
					cur_col_q <= stk_rd_s1[COORD_W-1:0];
					ev_q      <= EV_BACKTRACK;
					state_q   <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						rsp_row_q   <= cur_row_q;
						rsp_col_q   <= cur_col_q;
						rsp_ev_q    <= ev_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign cmd.ready     = (state_q == S_IDLE);
	assign rsp.valid     = rsp_valid_q;
	assign rsp.pos_row   = rsp_row_q;
	assign rsp.pos_col   = rsp_col_q;
	assign rsp.event_res = rsp_ev_q;

	// ------------------------------------------------------------------
	// Checks.
	`ASSERT_IMPLIES(a_walk_depth, clk, arst_n, status_q == WS_WALK, depth_q != '0,
		"walk in progress with an empty path stack")
	`ASSERT_IMPLIES(a_map_port, clk, arst_n, 1'b1, !(map_req.rd_en && map_req.wr_en),
		"cell map read and write in the same cycle")
	`ASSERT_IMPLIES(a_pop_depth, clk, arst_n, state_q == S_POP, depth_q >= DEPTH_W'(1),
		"backtrack left the path stack empty")
	`ASSERT_NEXT(a_move_push, clk, arst_n,
		state_q == S_NCHK && cell_free && !depth_q[STACK_AW],
		depth_q == $past(depth_q) + DEPTH_W'(1),
		"move did not grow the path stack")

endmodule

FILE: tb/maze_dfs_walker_tb.sv
// Self-checking testbench of the depth-first maze walker, with its own walk predictor.
`timescale 1ns / 100ps

module maze_dfs_walker_tb;
	import mdw_pkg::*;

	// Operation code the block must drop without touching the map or the walk.
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int IDLE_LIMIT       = 2000;
	localparam int RANDOM_ITEMS     = 700;
	localparam int SHOWN_MISMATCHES = 10;

	typedef enum logic [1:0] {
		WALK_IDLE,
		WALK_ON,
		WALK_GOAL,
		WALK_DEAD
	} walk_state_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [3:0] row;
		logic [3:0] col;
		logic       wall;
	} cmd_word_t;

	typedef struct packed {
		logic [3:0] pos_row;
		logic [3:0] pos_col;
		ev_t        event_res;
	} rsp_word_t;

	// One row of the directed table; want is only used where typed is set.
	typedef struct {
		cmd_word_t word;
		bit        typed;
		rsp_word_t want;
	} plan_row_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [USED_W-1:0] cfg_wdata;

	mdw_cmd_if cmd_ch();
	mdw_rsp_if rsp_ch();

	maze_dfs_walker u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd_ch),
		.rsp      (rsp_ch)
	);

	// Predicted copy of the walker: map, path stack, position and settings.
	logic [CELL_W-1:0]  m_cell [MAP_DEPTH];
	logic [POS_W-1:0]   m_stack [STACK_DEPTH];
	int                 m_depth;
	logic [COORD_W-1:0] m_row, m_col, m_entry_row, m_entry_col;
	walk_state_t        m_status;
	logic [USED_W-1:0]  m_rows_used, m_cols_used;
	logic [COORD_W-1:0] m_goal_row, m_goal_col;

	// Result words still owed by the block, oldest first.
	rsp_word_t awaited_words[$];
	plan_row_t directed_plan[$];

	int mismatches;
	int words_seen;
	int commands_sent;
	int walk_items;
	int settings_applied;
	int idle_cycles;
	int deepest_path;
	int full_stack_pushes;
	int event_tally[8];
	bit sender_rushed;
	bit sink_rushed;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Saturate a size setting at the axis limit and at the 4-bit coordinate range.
	function automatic int grid_extent(input logic [USED_W-1:0] used, input int axis_max);
		int v;
		v = used;
		if (v > axis_max)
			v = axis_max;
		if (v > 16)
			v = 16;
		return v;
	endfunction

	// A neighbor is free only inside the grid in use, open and not yet visited.
	function automatic bit open_cell(input int r, input int c);
		if (r >= grid_extent(m_rows_used, MAX_ROWS) || c >= grid_extent(m_cols_used, MAX_COLS))
			return 1'b0;
		return m_cell[r * MAX_COLS + c] == CELL_OPEN;
	endfunction

	// Push a position; a full stack keeps its depth and overwrites the top entry.
	function automatic void push_position(input logic [3:0] r, input logic [3:0] c);
		if (m_depth < STACK_DEPTH) begin
			m_stack[m_depth] = {r, c};
			m_depth++;
		end else begin
			m_stack[STACK_DEPTH-1] = {r, c};
			full_stack_pushes++;
		end
		if (m_depth > deepest_path)
			deepest_path = m_depth;
	endfunction

	// Advance the predicted walker by one command word and return the word it owes.
	function automatic rsp_word_t walk_response(input cmd_word_t w);
		rsp_word_t   o;
		ev_t         ev;
		int          r, c, nr, nc, idx;
		bit          found;
		logic [7:0]  top;
		ev = EV_IGNORED;
		idx = w.row * MAX_COLS + w.col;
		case (w.operation)
			OP_WRITE: begin
				// A write always drops the visited mark, even in the middle of a walk.
				m_cell[idx] = {1'b0, w.wall};
				ev = EV_WRITTEN;
			end
			OP_START: begin
				if (w.row < grid_extent(m_rows_used, MAX_ROWS) &&
						w.col < grid_extent(m_cols_used, MAX_COLS) &&
						!m_cell[idx][CELL_WALL_B]) begin
					m_entry_row = w.row;
					m_entry_col = w.col;
					m_row = w.row;
					m_col = w.col;
					m_cell[idx] = m_cell[idx] | CELL_VISITED;
					m_depth = 0;
					push_position(w.row, w.col);
					m_status = WALK_ON;
					ev = EV_STARTED;
				end else begin
					ev = EV_REJECTED;
				end
			end
			OP_STEP: begin
				if (m_status == WALK_ON) begin
					r = m_row;
					c = m_col;
					nr = r;
					nc = c;
					found = 1'b1;
					if (m_row == m_goal_row && m_col == m_goal_col) begin
						m_status = WALK_GOAL;
						ev = EV_GOAL;
					end else begin
						// Probe order: left, right, down, up.
						if (c > 0 && open_cell(r, c - 1))
							nc = c - 1;
						else if (open_cell(r, c + 1))
							nc = c + 1;
						else if (open_cell(r + 1, c))
							nr = r + 1;
						else if (r > 0 && open_cell(r - 1, c))
							nr = r - 1;
						else
							found = 1'b0;
						if (found) begin
							m_row = nr[3:0];
							m_col = nc[3:0];
							m_cell[nr * MAX_COLS + nc] = m_cell[nr * MAX_COLS + nc] | CELL_VISITED;
							push_position(nr[3:0], nc[3:0]);
							ev = EV_MOVED;
						end else if ((m_row == m_entry_row && m_col == m_entry_col) ||
								m_depth <= 1) begin
							m_status = WALK_DEAD;
							ev = EV_UNREACH;
						end else begin
							m_depth--;
							top = m_stack[(m_depth - 1) % STACK_DEPTH];
							m_row = top[7:4];
							m_col = top[3:0];
							ev = EV_BACKTRACK;
						end
					end
				end
			end
			default: ;
		endcase
		o.pos_row = m_row;
		o.pos_col = m_col;
		o.event_res = ev;
		return o;
	endfunction

	function automatic logic [USED_W-1:0] draw_extent();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 5'd1;
		if (pick == 1)
			return 5'd16;
		if (pick == 2)
			return $urandom_range(0, 31);
		return $urandom_range(2, 7);
	endfunction

	// Pick a coordinate inside the grid in use, or anywhere when the grid is empty.
	function automatic logic [3:0] draw_coord(input int extent);
		return (extent > 0) ? $urandom_range(0, extent - 1) : $urandom_range(0, 15);
	endfunction

	task automatic plan_row(input logic [1:0] op, input logic [3:0] r, input logic [3:0] c,
			input logic wall, input bit typed, input logic [3:0] er, input logic [3:0] ec,
			input ev_t ev);
		plan_row_t p;
		p.word = '{op, r, c, wall};
		p.typed = typed;
		p.want = '{er, ec, ev};
		directed_plan.push_back(p);
	endtask

	// Offer one command word after a random gap, then log what the block owes for it.
	task automatic issue_command(input cmd_word_t w, input bit typed, input rsp_word_t want);
		int        gap;
		rsp_word_t predicted;
		gap = sender_rushed ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.operation <= w.operation;
		cmd_ch.row       <= w.row;
		cmd_ch.col       <= w.col;
		cmd_ch.wall      <= w.wall;
		do @(posedge clk); while (!cmd_ch.ready);
		predicted = walk_response(w);
		awaited_words.push_back(typed ? want : predicted);
		commands_sent++;
		if (predicted.event_res != EV_IGNORED)
			walk_items++;
	endtask

	task automatic send_word(input logic [1:0] op, input logic [3:0] r, input logic [3:0] c,
			input logic wall);
		issue_command('{op, r, c, wall}, 1'b0, '0);
	endtask

	// Hold the command channel until every owed word is back, then let the block settle.
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		while (awaited_words.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all four settings back to back; only called while the block is idle.
	task automatic program_grid(input logic [4:0] rows, input logic [4:0] cols,
			input logic [4:0] grow, input logic [4:0] gcol);
		logic [USED_W-1:0] vals [4];
		vals[CFG_ROWS_USED] = rows;
		vals[CFG_COLS_USED] = cols;
		vals[CFG_GOAL_ROW]  = grow;
		vals[CFG_GOAL_COL]  = gcol;
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		m_rows_used = rows;
		m_cols_used = cols;
		m_goal_row = grow[3:0];
		m_goal_col = gcol[3:0];
		settings_applied++;
		repeat (2) @(posedge clk);
	endtask

	// Result side: stall at random, check each accepted word against the oldest owed one.
	initial begin
		rsp_word_t got, want;
		int        stall, since_mode;
		rsp_ch.ready <= 1'b0;
		since_mode = 0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			// Switch between stalling and full-rate stretches every few dozen words.
			if (since_mode == 0) begin
				sink_rushed = ($urandom_range(0, 2) == 0);
				since_mode = 40;
			end
			since_mode--;
			stall = sink_rushed ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			got.pos_row = rsp_ch.pos_row;
			got.pos_col = rsp_ch.pos_col;
			got.event_res = ev_t'(rsp_ch.event_res);
			words_seen++;
			event_tally[got.event_res]++;
			if (awaited_words.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES)
					$display("%0t: result word with none owed: row %0d col %0d event %s",
						$realtime, got.pos_row, got.pos_col, got.event_res.name());
			end else begin
				want = awaited_words.pop_front();
				if (got.pos_row !== want.pos_row || got.pos_col !== want.pos_col ||
						got.event_res !== want.event_res) begin
					mismatches++;
					if (mismatches <= SHOWN_MISMATCHES)
						$display("%0t: word %0d expected row %0d col %0d %s, got row %0d col %0d %s",
							$realtime, words_seen, want.pos_row, want.pos_col,
							want.event_res.name(), got.pos_row, got.pos_col,
							got.event_res.name());
				end
			end
		end
	end

	// Watchdog: end the run when no word moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog: no word moved for %0d cycles, %0d still owed",
				idle_cycles, awaited_words.size());
			$display("FAILED: results differ");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus: directed table, a walk that overfills the path stack, then random mazes.
	initial begin
		int          r_lim, c_lim, n, k, ep;
		logic [4:0]  rows, cols, grow, gcol;
		logic [3:0]  er, ec;
		cmd_ch.valid     <= 1'b0;
		cmd_ch.operation <= OP_WRITE;
		cmd_ch.row       <= '0;
		cmd_ch.col       <= '0;
		cmd_ch.wall      <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= CFG_ROWS_USED;
		cfg_wdata        <= '0;
		arst_n           <= 1'b0;
		sender_rushed = 1'b0;

		// Predicted state after reset: open map, idle walk, 10 x 12 grid, goal at (4, 11).
		for (int i = 0; i < MAP_DEPTH; i++)
			m_cell[i] = CELL_OPEN;
		for (int i = 0; i < STACK_DEPTH; i++)
			m_stack[i] = '0;
		m_depth = 0;
		m_row = '0;
		m_col = '0;
		m_entry_row = '0;
		m_entry_col = '0;
		m_status = WALK_IDLE;
		m_rows_used = 5'd10;
		m_cols_used = 5'd12;
		m_goal_row = 4'd4;
		m_goal_col = 4'd11;

		// Step while idle and the unused code are dropped; out-of-grid and walled entrances
		// are rejected; a boxed-in entrance is unreachable; starting on the goal ends at once.
		plan_row(OP_STEP,    4'd0,  4'd0,  1'b0, 1, 4'd0, 4'd0,  EV_IGNORED);
		plan_row(OP_UNUSED,  4'd15, 4'd15, 1'b1, 1, 4'd0, 4'd0,  EV_IGNORED);
		plan_row(OP_WRITE,   4'd15, 4'd15, 1'b1, 1, 4'd0, 4'd0,  EV_WRITTEN);
		plan_row(OP_START,   4'd15, 4'd15, 1'b0, 1, 4'd0, 4'd0,  EV_REJECTED);
		plan_row(OP_START,   4'd9,  4'd12, 1'b0, 1, 4'd0, 4'd0,  EV_REJECTED);
		plan_row(OP_START,   4'd10, 4'd0,  1'b0, 1, 4'd0, 4'd0,  EV_REJECTED);
		plan_row(OP_WRITE,   4'd0,  4'd1,  1'b1, 1, 4'd0, 4'd0,  EV_WRITTEN);
		plan_row(OP_WRITE,   4'd1,  4'd0,  1'b1, 1, 4'd0, 4'd0,  EV_WRITTEN);
		plan_row(OP_START,   4'd0,  4'd1,  1'b0, 1, 4'd0, 4'd0,  EV_REJECTED);
		plan_row(OP_START,   4'd0,  4'd0,  1'b0, 1, 4'd0, 4'd0,  EV_STARTED);
		plan_row(OP_STEP,    4'd0,  4'd0,  1'b0, 1, 4'd0, 4'd0,  EV_UNREACH);
		plan_row(OP_STEP,    4'd0,  4'd0,  1'b0, 1, 4'd0, 4'd0,  EV_IGNORED);
		plan_row(OP_START,   4'd4,  4'd11, 1'b0, 1, 4'd4, 4'd11, EV_STARTED);
		plan_row(OP_STEP,    4'd0,  4'd0,  1'b0, 1, 4'd4, 4'd11, EV_GOAL);
		plan_row(OP_STEP,    4'd0,  4'd0,  1'b0, 1, 4'd4, 4'd11, EV_IGNORED);
		// Short pocket on the bottom row: move right, back off, then give up at the entrance.
		plan_row(OP_WRITE,   4'd8,  4'd0,  1'b1, 1, 4'd4, 4'd11, EV_WRITTEN);
		plan_row(OP_WRITE,   4'd8,  4'd1,  1'b1, 1, 4'd4, 4'd11, EV_WRITTEN);
		plan_row(OP_WRITE,   4'd9,  4'd2,  1'b1, 1, 4'd4, 4'd11, EV_WRITTEN);
		plan_row(OP_START,   4'd9,  4'd0,  1'b0, 1, 4'd9, 4'd0,  EV_STARTED);
		plan_row(OP_STEP,    4'd0,  4'd0,  1'b0, 0, 4'd0, 4'd0,  EV_IGNORED);
		plan_row(OP_STEP,    4'd0,  4'd0,  1'b0, 0, 4'd0, 4'd0,  EV_IGNORED);
		plan_row(OP_STEP,    4'd0,  4'd0,  1'b0, 0, 4'd0, 4'd0,  EV_IGNORED);
		// Walls left, right and the grid edge below leave only the upward move.
		plan_row(OP_WRITE,   4'd9,  4'd4,  1'b1, 0, 4'd0, 4'd0,  EV_IGNORED);
		plan_row(OP_START,   4'd9,  4'd3,  1'b0, 1, 4'd9, 4'd3,  EV_STARTED);
		plan_row(OP_STEP,    4'd0,  4'd0,  1'b0, 0, 4'd0, 4'd0,  EV_IGNORED);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i])
			issue_command(directed_plan[i].word, directed_plan[i].typed, directed_plan[i].want);
		settle();

		// Full 16 x 16 grid with the goal walled off at (15, 0): the walk snakes through
		// every other cell, then rewrites behind it clear visited marks so the stack overfills.
		walk_items = 0;
		program_grid(5'd16, 5'd16, 5'd15, 5'd0);
		for (int i = 0; i < MAP_DEPTH; i++)
			if (m_cell[i] != CELL_OPEN)
				send_word(OP_WRITE, i / MAX_COLS, i % MAX_COLS, 1'b0);
		send_word(OP_WRITE, 4'd15, 4'd0, 1'b1);
		send_word(OP_START, 4'd0, 4'd0, 1'b0);
		repeat (254) send_word(OP_STEP, 4'd0, 4'd0, 1'b0);
		send_word(OP_WRITE, 4'd15, 4'd2, 1'b0);
		send_word(OP_STEP, 4'd0, 4'd0, 1'b0);
		send_word(OP_WRITE, 4'd15, 4'd1, 1'b0);
		send_word(OP_STEP, 4'd0, 4'd0, 1'b0);
		send_word(OP_WRITE, 4'd15, 4'd2, 1'b0);
		repeat (13) send_word(OP_STEP, 4'd0, 4'd0, 1'b0);

		// Random mazes: settings drawn per episode, the early ones pinned to the extremes.
		ep = 0;
		while (walk_items < RANDOM_ITEMS) begin
			settle();
			case (ep)
				0: begin rows = 5'd1;  cols = 5'd16; end
				1: begin rows = 5'd0;  cols = 5'd5;  end
				2: begin rows = 5'd31; cols = 5'd17; end
				3: begin rows = 5'd16; cols = 5'd1;  end
				default: begin
					rows = draw_extent();
					cols = draw_extent();
				end
			endcase
			r_lim = grid_extent(rows, MAX_ROWS);
			c_lim = grid_extent(cols, MAX_COLS);
			if (r_lim > 0 && c_lim > 0 && $urandom_range(0, 4) != 0) begin
				grow = draw_coord(r_lim);
				gcol = draw_coord(c_lim);
			end else begin
				grow = $urandom_range(0, 31);
				gcol = $urandom_range(0, 31);
			end
			program_grid(rows, cols, grow, gcol);
			sender_rushed = ($urandom_range(0, 3) == 0);

			// Lay out the maze; large grids only get a random subset rewritten.
			if (r_lim * c_lim <= 64) begin
				for (int r = 0; r < r_lim; r++)
					for (int c = 0; c < c_lim; c++)
						send_word(OP_WRITE, r, c, $urandom_range(0, 99) < 30);
			end else begin
				repeat (48)
					send_word(OP_WRITE, draw_coord(r_lim), draw_coord(c_lim),
						$urandom_range(0, 99) < 30);
			end
			repeat (2)
				send_word(OP_WRITE, $urandom_range(0, 15), $urandom_range(0, 15),
					$urandom_range(0, 1));

			if (r_lim > 0 && c_lim > 0 && $urandom_range(0, 6) != 0) begin
				er = draw_coord(r_lim);
				ec = draw_coord(c_lim);
			end else begin
				er = $urandom_range(0, 15);
				ec = $urandom_range(0, 15);
			end
			if ($urandom_range(0, 4) != 0)
				send_word(OP_WRITE, er, ec, 1'b0);
			send_word(OP_START, er, ec, 1'b0);

			// Walk until the search ends, with a little noise mixed in.
			n = 0;
			while (n < 3 * r_lim * c_lim + 6 && (m_status == WALK_ON || n < 2)) begin
				k = $urandom_range(0, 99);
				if (k < 4)
					send_word(OP_WRITE, draw_coord(r_lim), draw_coord(c_lim),
						$urandom_range(0, 1));
				else if (k < 7)
					send_word(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15),
						$urandom_range(0, 1));
				else if (k < 9)
					send_word(OP_START, draw_coord(r_lim), draw_coord(c_lim), 1'b0);
				else
					send_word(OP_STEP, $urandom_range(0, 15), $urandom_range(0, 15),
						$urandom_range(0, 1));
				n++;
			end
			repeat (2) send_word(OP_STEP, 4'd0, 4'd0, 1'b0);
			ep++;
		end

		settle();
		repeat (20) @(posedge clk);

		$display("Sent %0d command words over %0d grid settings, %0d result words back;",
			commands_sent, settings_applied, words_seen);
		$display("moves %0d, backtracks %0d, goals %0d, dead mazes %0d, rejected starts %0d, deepest path %0d, full-stack pushes %0d.",
			event_tally[EV_MOVED], event_tally[EV_BACKTRACK], event_tally[EV_GOAL],
			event_tally[EV_UNREACH], event_tally[EV_REJECTED], deepest_path,
			full_stack_pushes);
		if (mismatches == 0 && awaited_words.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
